// ----- rtl/core/gec_pkg.sv -----
// ----------------------------------------------------------------------------
// gec_pkg: shared types and constants for the coordinate converter
// Internal angles use 2^32 units to a turn; sines, cosines and products are
// Q30 fixed point held in 34-bit signed words.
// ----------------------------------------------------------------------------
package gec_pkg;

   localparam int ROT_STEPS  = 30;
   localparam int VEC_STEPS  = 30;
   localparam int SQRT_STEPS = 31;

   localparam int Q_W = 34;
   localparam int V_W = 36;
   localparam int Z_W = 34;

   typedef logic signed [Q_W-1:0] q_type;
   typedef logic signed [V_W-1:0] v_type;
   typedef logic signed [Z_W-1:0] z_type;

   localparam q_type CORDIC_GAIN = 34'sd652032874;
   localparam q_type ONE_Q30     = 34'sd1073741824;

   localparam logic [31:0] POLE_RA_RESET  = 32'd2300903558;
   localparam logic [31:0] POLE_DEC_RESET = 32'd323653635;
   localparam logic [31:0] NODE_RESET     = 32'd393705335;

   typedef enum logic [1:0] {
      REG_POLE_RA  = 2'd0,
      REG_POLE_DEC = 2'd1,
      REG_NODE     = 2'd2
   } reg_index_type;

   typedef struct packed {
      logic [31:0] pole_ra;
      logic [31:0] pole_dec;
      logic [31:0] node;
   } cfg_type;

   // Arctangent of 2^-i in internal angle units.
   function automatic logic [29:0] atan_entry(input logic [4:0] i);
      logic [29:0] v;
      unique case (i)
         5'd0:  v = 30'h20000000;
         5'd1:  v = 30'h12E4051E;
         5'd2:  v = 30'h09FB385B;
         5'd3:  v = 30'h051111D4;
         5'd4:  v = 30'h028B0D43;
         5'd5:  v = 30'h0145D7E1;
         5'd6:  v = 30'h00A2F61E;
         5'd7:  v = 30'h00517C55;
         5'd8:  v = 30'h0028BE53;
         5'd9:  v = 30'h00145F2F;
         5'd10: v = 30'h000A2F98;
         5'd11: v = 30'h000517CC;
         5'd12: v = 30'h00028BE6;
         5'd13: v = 30'h000145F3;
         5'd14: v = 30'h0000A2F9;
         5'd15: v = 30'h0000517C;
         5'd16: v = 30'h000028BE;
         5'd17: v = 30'h0000145F;
         5'd18: v = 30'h00000A2F;
         5'd19: v = 30'h00000517;
         5'd20: v = 30'h0000028B;
         5'd21: v = 30'h00000145;
         5'd22: v = 30'h000000A2;
         5'd23: v = 30'h00000051;
         5'd24: v = 30'h00000028;
         5'd25: v = 30'h00000014;
         5'd26: v = 30'h0000000A;
         5'd27: v = 30'h00000005;
         5'd28: v = 30'h00000002;
         5'd29: v = 30'h00000001;
         default: v = 30'h0;
      endcase
      return v;
   endfunction

   // Q30 product rounded to nearest, ties upwards.
   function automatic q_type qmul(input q_type a, input q_type b);
      logic signed [2*Q_W-1:0] p;
      p = a * b + (68'sd1 <<< 29);
      return q_type'(p >>> 30);
   endfunction

endpackage

// ----- rtl/core/gec_core.sv -----
// ----------------------------------------------------------------------------
// gec_core: pipelined conversion datapath
// Three rotation CORDIC lanes, a product section, a bit-per-stage square
// root and two vectoring CORDIC lanes, one stage per register.
// ----------------------------------------------------------------------------
module gec_core (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_stall,
   input  logic            in_kind,
   input  logic [31:0]     in_longitude,
   input  logic [31:0]     in_latitude,
   input  gec_pkg::cfg_type cfg,
   output logic            out_valid,
   input  logic            out_stall,
   output logic [31:0]     out_longitude,
   output logic [31:0]     out_latitude
);
   import gec_pkg::*;

   localparam int ST_RESTORE = ROT_STEPS + 1;
   localparam int ST_P1      = ST_RESTORE + 1;
   localparam int ST_P2      = ST_P1 + 1;
   localparam int ST_P3      = ST_P2 + 1;
   localparam int ST_ROOT    = ST_P3 + 1;
   localparam int ST_VEC     = ST_ROOT + SQRT_STEPS + 1;
   localparam int ST_LAST    = ST_VEC + VEC_STEPS + 1;
   localparam int DEPTH      = ST_LAST + 1;

   logic adv;
   logic [DEPTH-1:0] valid_ff, valid_in;
   logic [DEPTH-1:0] kind_ff, kind_in;

   // Rotation lanes: 0 latitude, 1 pole declination, 2 longitude difference.
   logic [31:0] ang [0:2];
   logic [1:0]  fold_q [0:2];
   logic [31:0] fold_r [0:2];
   q_type       rx_ff [0:ROT_STEPS][0:2], rx_in [0:ROT_STEPS][0:2];
   q_type       ry_ff [0:ROT_STEPS][0:2], ry_in [0:ROT_STEPS][0:2];
   q_type       rz_ff [0:ROT_STEPS][0:2], rz_in [0:ROT_STEPS][0:2];
   logic [1:0]  rq_ff [0:ROT_STEPS][0:2], rq_in [0:ROT_STEPS][0:2];

   q_type sn_ff [0:2], sn_in [0:2];
   q_type cs_ff [0:2], cs_in [0:2];

   q_type t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in, t4_ff, t4_in;
   q_type p1_cb_ff, p1_su_ff, p1_cu_ff;
   q_type w_sel, m_sel;
   q_type t5_ff, t5_in, t6_ff, t6_in, t7_ff, t7_in, p2_t1_ff, p2_t3_ff;
   q_type diff;
   q_type s_ff, s_in, ly_ff, ly_in, lx_ff, lx_in;

   q_type              s_sat;
   logic signed [31:0] s_narrow;
   logic signed [63:0] s_sq;
   logic [61:0] rt_n_ff [0:SQRT_STEPS], rt_n_in [0:SQRT_STEPS];
   logic [61:0] rt_r_ff [0:SQRT_STEPS], rt_r_in [0:SQRT_STEPS];
   q_type       rt_s_ff [0:SQRT_STEPS], rt_s_in [0:SQRT_STEPS];
   q_type       rt_ly_ff [0:SQRT_STEPS], rt_ly_in [0:SQRT_STEPS];
   q_type       rt_lx_ff [0:SQRT_STEPS], rt_lx_in [0:SQRT_STEPS];

   // Vectoring lanes: 0 arcsine, 1 output longitude.
   v_type px [0:1], py [0:1];
   v_type vx_ff [0:VEC_STEPS][0:1], vx_in [0:VEC_STEPS][0:1];
   v_type vy_ff [0:VEC_STEPS][0:1], vy_in [0:VEC_STEPS][0:1];
   z_type vz_ff [0:VEC_STEPS][0:1], vz_in [0:VEC_STEPS][0:1];
   logic  vb_ff [0:VEC_STEPS][0:1], vb_in [0:VEC_STEPS][0:1];
   logic  v0_ff [0:VEC_STEPS][0:1], v0_in [0:VEC_STEPS][0:1];

   logic [31:0]        res_ang [0:1];
   logic signed [31:0] lat_raw;
   logic [31:0]        lon_ff, lon_in, lat_ff, lat_in;

   // The whole pipe holds while the finished result waits to be taken.
   assign adv      = !(valid_ff[ST_LAST] && out_stall);
   assign in_stall = !adv;
   assign valid_in = {valid_ff[DEPTH-2:0], in_valid};
   assign kind_in  = {kind_ff[DEPTH-2:0], in_kind};

   assign ang[0] = in_latitude;
   assign ang[1] = cfg.pole_dec;
   assign ang[2] = in_longitude - (in_kind ? cfg.pole_ra : cfg.node);

   for (genvar l = 0; l < 3; l++) begin : g_fold
      assign fold_q[l]   = 2'((ang[l] + 32'h2000_0000) >> 30);
      assign fold_r[l]   = ang[l] - {fold_q[l], 30'd0};
      assign rx_in[0][l] = CORDIC_GAIN;
      assign ry_in[0][l] = '0;
      assign rz_in[0][l] = q_type'(signed'(fold_r[l]));
      assign rq_in[0][l] = fold_q[l];
   end

   for (genvar i = 0; i < ROT_STEPS; i++) begin : g_rot
      localparam q_type TAB = q_type'({4'd0, atan_entry(5'(i))});
      for (genvar l = 0; l < 3; l++) begin : g_lane
         logic neg;
         assign neg = rz_ff[i][l][Q_W-1];
         assign rx_in[i+1][l] = neg ? rx_ff[i][l] + (ry_ff[i][l] >>> i)
                                    : rx_ff[i][l] - (ry_ff[i][l] >>> i);
         assign ry_in[i+1][l] = neg ? ry_ff[i][l] - (rx_ff[i][l] >>> i)
                                    : ry_ff[i][l] + (rx_ff[i][l] >>> i);
         assign rz_in[i+1][l] = neg ? rz_ff[i][l] + TAB : rz_ff[i][l] - TAB;
         assign rq_in[i+1][l] = rq_ff[i][l];
      end
   end

   // Put the folded quarter turns back.
   for (genvar l = 0; l < 3; l++) begin : g_restore
      logic [1:0] q;
      q_type      x, y;
      assign q = rq_ff[ROT_STEPS][l];
      assign x = rx_ff[ROT_STEPS][l];
      assign y = ry_ff[ROT_STEPS][l];
      assign cs_in[l] = (q == 2'd0) ? x : (q == 2'd1) ? -y : (q == 2'd2) ? -x : y;
      assign sn_in[l] = (q == 2'd0) ? y : (q == 2'd1) ? x : (q == 2'd2) ? -y : -x;
   end

   assign t1_in = qmul(sn_ff[0], sn_ff[1]);
   assign t2_in = qmul(cs_ff[0], cs_ff[1]);
   assign t3_in = qmul(sn_ff[0], cs_ff[1]);
   assign t4_in = qmul(cs_ff[0], sn_ff[1]);

   assign w_sel = kind_ff[ST_P1] ? p1_cu_ff : p1_su_ff;
   assign m_sel = kind_ff[ST_P1] ? p1_su_ff : p1_cu_ff;
   assign t5_in = qmul(t2_ff, w_sel);
   assign t6_in = qmul(t4_ff, w_sel);
   assign t7_in = qmul(p1_cb_ff, m_sel);

   assign diff  = p2_t3_ff - t6_ff;
   assign s_in  = p2_t1_ff + t5_ff;
   assign ly_in = kind_ff[ST_P2] ? diff : t7_ff;
   assign lx_in = kind_ff[ST_P2] ? t7_ff : diff;

   // Cosine of the output latitude as the root of one minus the sine squared.
   assign s_sat = (s_ff > ONE_Q30) ? ONE_Q30 : (s_ff < -ONE_Q30) ? -ONE_Q30 : s_ff;
   assign s_narrow = 32'(s_sat);
   assign s_sq     = s_narrow * s_narrow;
   assign rt_n_in[0]  = 62'(64'h1000_0000_0000_0000 - 64'(s_sq));
   assign rt_r_in[0]  = '0;
   assign rt_s_in[0]  = s_sat;
   assign rt_ly_in[0] = ly_ff;
   assign rt_lx_in[0] = lx_ff;

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_root
      localparam logic [61:0] BIT = 62'(1) << (2 * (SQRT_STEPS - 1 - k));
      logic [61:0] trial;
      logic        take;
      assign trial = rt_r_ff[k] + BIT;
      assign take  = rt_n_ff[k] >= trial;
      assign rt_n_in[k+1]  = take ? rt_n_ff[k] - trial : rt_n_ff[k];
      assign rt_r_in[k+1]  = take ? (rt_r_ff[k] >> 1) + BIT : rt_r_ff[k] >> 1;
      assign rt_s_in[k+1]  = rt_s_ff[k];
      assign rt_ly_in[k+1] = rt_ly_ff[k];
      assign rt_lx_in[k+1] = rt_lx_ff[k];
   end

   assign py[0] = v_type'(rt_s_ff[SQRT_STEPS]);
   assign px[0] = v_type'(rt_r_ff[SQRT_STEPS]);
   assign py[1] = v_type'(rt_ly_ff[SQRT_STEPS]);
   assign px[1] = v_type'(rt_lx_ff[SQRT_STEPS]);

   // A left half-plane vector is turned by half a turn before the steps.
   for (genvar l = 0; l < 2; l++) begin : g_vpre
      logic neg;
      assign neg         = px[l][V_W-1];
      assign vx_in[0][l] = neg ? -px[l] : px[l];
      assign vy_in[0][l] = neg ? -py[l] : py[l];
      assign vz_in[0][l] = '0;
      assign vb_in[0][l] = neg;
      assign v0_in[0][l] = (px[l] == '0) && (py[l] == '0);
   end

   for (genvar i = 0; i < VEC_STEPS; i++) begin : g_vec
      localparam z_type TAB = z_type'({4'd0, atan_entry(5'(i))});
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic pos;
         assign pos = !vy_ff[i][l][V_W-1];
         assign vx_in[i+1][l] = pos ? vx_ff[i][l] + (vy_ff[i][l] >>> i)
                                    : vx_ff[i][l] - (vy_ff[i][l] >>> i);
         assign vy_in[i+1][l] = pos ? vy_ff[i][l] - (vx_ff[i][l] >>> i)
                                    : vy_ff[i][l] + (vx_ff[i][l] >>> i);
         assign vz_in[i+1][l] = pos ? vz_ff[i][l] + TAB : vz_ff[i][l] - TAB;
         assign vb_in[i+1][l] = vb_ff[i][l];
         assign v0_in[i+1][l] = v0_ff[i][l];
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_vpost
      assign res_ang[l] = v0_ff[VEC_STEPS][l] ? 32'd0 :
                          32'(vz_ff[VEC_STEPS][l]) + {vb_ff[VEC_STEPS][l], 31'd0};
   end

   assign lat_raw = signed'(res_ang[0]);
   assign lat_in  = (lat_raw > 32'sd1073741824)  ? 32'h4000_0000 :
                    (lat_raw < -32'sd1073741824) ? 32'hC000_0000 : res_ang[0];
   assign lon_in  = res_ang[1] + (kind_ff[ST_VEC + VEC_STEPS] ? cfg.node : cfg.pole_ra);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         kind_ff  <= kind_in;
         rx_ff    <= rx_in;
         ry_ff    <= ry_in;
         rz_ff    <= rz_in;
         rq_ff    <= rq_in;
         sn_ff    <= sn_in;
         cs_ff    <= cs_in;
         t1_ff    <= t1_in;
         t2_ff    <= t2_in;
         t3_ff    <= t3_in;
         t4_ff    <= t4_in;
         p1_cb_ff <= cs_ff[0];
         p1_su_ff <= sn_ff[2];
         p1_cu_ff <= cs_ff[2];
         t5_ff    <= t5_in;
         t6_ff    <= t6_in;
         t7_ff    <= t7_in;
         p2_t1_ff <= t1_ff;
         p2_t3_ff <= t3_ff;
         s_ff     <= s_in;
         ly_ff    <= ly_in;
         lx_ff    <= lx_in;
         rt_n_ff  <= rt_n_in;
         rt_r_ff  <= rt_r_in;
         rt_s_ff  <= rt_s_in;
         rt_ly_ff <= rt_ly_in;
         rt_lx_ff <= rt_lx_in;
         vx_ff    <= vx_in;
         vy_ff    <= vy_in;
         vz_ff    <= vz_in;
         vb_ff    <= vb_in;
         v0_ff    <= v0_in;
         lon_ff   <= lon_in;
         lat_ff   <= lat_in;
      end
   end

   assign out_valid     = valid_ff[ST_LAST];
   assign out_longitude = lon_ff;
   assign out_latitude  = lat_ff;

endmodule

// ----- rtl/core/galactic_equatorial_convert.sv -----
// ----------------------------------------------------------------------------
// galactic_equatorial_convert: galactic and equatorial sky position converter
//
//   Channel   Direction  Fields                                  Handshake
//   req       in         kind, in_longitude, in_latitude         valid/stall
//   rsp       out        out_longitude, out_latitude             valid/stall
//   csr       in/out     pole_right_ascension, pole_declination,  APB, no wait
//                        node_longitude
//
// One position enters per cycle while req_stall is low; each result passes the
// rotation CORDIC, products, root and vectoring CORDIC, one register per step.
// Reset empties the pipe and loads the standard pole and node angles.
// While a result waits under rsp_stall the whole pipe holds and req_stall
// is raised; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module galactic_equatorial_convert #(
   parameter  int ANGLE_BITS = 32,
   localparam int CSR_DATA_W = (ANGLE_BITS > 32) ? 64 : 32,
   localparam int CSR_ADDR_W = (ANGLE_BITS > 32) ? 5 : 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_kind,
   input  logic        [ANGLE_BITS-1:0] req_in_longitude,
   input  logic signed [ANGLE_BITS-1:0] req_in_latitude,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic        [ANGLE_BITS-1:0] rsp_out_longitude,
   output logic signed [ANGLE_BITS-1:0] rsp_out_latitude,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic        [CSR_ADDR_W-1:0] csr_paddr,
   input  logic        [CSR_DATA_W-1:0] csr_pwdata,
   output logic        [CSR_DATA_W-1:0] csr_prdata,
   output logic                         csr_pready
);
   import gec_pkg::*;

   localparam int SH_DOWN = (ANGLE_BITS > 32) ? ANGLE_BITS - 32 : 0;
   localparam int SH_UP   = (ANGLE_BITS < 32) ? 32 - ANGLE_BITS : 0;

   cfg_type       cfg_ff, cfg_in;
   reg_index_type csr_index;
   logic          csr_write;
   logic [31:0]   wdata_int;
   logic [31:0]   core_lon, core_lat;

   // Port angles to and from the internal 2^32-per-turn scale.
   function automatic logic [31:0] to_int(input logic [ANGLE_BITS-1:0] v);
      return 32'(v >> SH_DOWN) << SH_UP;
   endfunction

   function automatic logic [ANGLE_BITS-1:0] from_int(input logic [31:0] a);
      return ANGLE_BITS'(a >> SH_UP) << SH_DOWN;
   endfunction

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_index  = reg_index_type'(csr_paddr[CSR_ADDR_W-1 -: 2]);
   assign wdata_int  = to_int(csr_pwdata[ANGLE_BITS-1:0]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_POLE_RA:  cfg_in.pole_ra  = wdata_int;
            REG_POLE_DEC: cfg_in.pole_dec = wdata_int;
            REG_NODE:     cfg_in.node     = wdata_int;
            default:      cfg_in          = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_POLE_RA:  csr_prdata = CSR_DATA_W'(from_int(cfg_ff.pole_ra));
         REG_POLE_DEC: csr_prdata = CSR_DATA_W'(from_int(cfg_ff.pole_dec));
         REG_NODE:     csr_prdata = CSR_DATA_W'(from_int(cfg_ff.node));
         default:      csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pole_ra  <= POLE_RA_RESET;
         cfg_ff.pole_dec <= POLE_DEC_RESET;
         cfg_ff.node     <= NODE_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   gec_core u_core (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_stall      (req_stall),
      .in_kind       (req_kind),
      .in_longitude  (to_int(req_in_longitude)),
      .in_latitude   (to_int(req_in_latitude)),
      .cfg           (cfg_ff),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_longitude (core_lon),
      .out_latitude  (core_lat)
   );

   assign rsp_out_longitude = from_int(core_lon);
   assign rsp_out_latitude  = signed'(from_int(core_lat));

endmodule

// ----- rtl/core/gec_checker.sv -----
// ----------------------------------------------------------------------------
// gec_checker: port-level checks for the coordinate converter
// Watches reset, stall coupling, the hold of a stalled result and the range of the result latitude.
// ----------------------------------------------------------------------------
module gec_checker #(
   parameter int ANGLE_BITS = 32
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_stall,
   input logic                         rsp_valid,
   input logic                         rsp_stall,
   input logic        [ANGLE_BITS-1:0] rsp_out_longitude,
   input logic signed [ANGLE_BITS-1:0] rsp_out_latitude
);
   localparam logic signed [ANGLE_BITS-1:0] QUARTER = ANGLE_BITS'(1) << (ANGLE_BITS - 2);

   // Reset empties the pipe.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown after reset");

   // Input is held back exactly while a result beat waits.
   a_stall_link: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow the waiting result");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_longitude)
                                 && $stable(rsp_out_latitude))
      else $error("stalled result beat changed");

   a_lat_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_latitude <= QUARTER) && (rsp_out_latitude >= -QUARTER))
      else $error("result latitude beyond a quarter turn");

endmodule

bind galactic_equatorial_convert gec_checker #(.ANGLE_BITS(ANGLE_BITS)) u_checker (.*);
